// ===== sv/rar_pkg.sv =====
package rar_pkg;

	// Operation codes carried on the action field.
	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_GCD  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} back_state_t;

	localparam int TAG_BITS = 6;

endpackage

// ===== sv/rational_arith_reduce.sv =====
// Exact arithmetic on two positive fractions, reduced to lowest terms.
//
// Input channel: a beat is taken when push is high and full is low. It
// carries action (add, subtract, multiply, divide), the two fractions and
// a tag. Result channel: while empty is low the oldest result sits on
// result_num, result_den, negative and result_tag; a beat leaves when pop
// is high. A zero denominator yields 0/0, a zero numerator yields 0/1.
//
// The front forms the cross products in its s1 and s2 registers, then the
// back sequencer runs the binary-gcd loop one step a cycle (the step count
// is data dependent) and divides both parts by the gcd one quotient bit a
// cycle. The back takes a new item only after its last result has moved
// into the output register, so the gcd/divide unit sets the throughput.
//
// A two-entry queue parts the front from the back, and the result sits in
// an output register, so new beats are taken while a result waits. When
// the receiver stalls, the result holds, the back stops after its current
// item, then the queue and front fill and full rises.
// Reset clears all valid state; no result is pending after it.
module rational_arith_reduce #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    action,
	input  logic [OPERAND_BITS-1:0]       first_num,
	input  logic [OPERAND_BITS-1:0]       first_den,
	input  logic [OPERAND_BITS-1:0]       second_num,
	input  logic [OPERAND_BITS-1:0]       second_den,
	input  logic [rar_pkg::TAG_BITS-1:0]  task_tag,
	output logic                          empty,
	input  logic                          pop,
	output logic [2*OPERAND_BITS:0]       result_num,
	output logic [2*OPERAND_BITS-1:0]     result_den,
	output logic                          negative,
	output logic [rar_pkg::TAG_BITS-1:0]  result_tag
);

	localparam int QW = 2 * OPERAND_BITS + 1 + 2 * OPERAND_BITS + 2 + rar_pkg::TAG_BITS;

	logic          wr_valid, wr_ready;
	logic [QW-1:0] wr_data;
	logic          rd_valid, rd_ready;
	logic [QW-1:0] rd_data;

	// Front: take beats, form products, combine by action.
	rar_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.first_num  (first_num),
		.first_den  (first_den),
		.second_num (second_num),
		.second_den (second_den),
		.task_tag   (task_tag),
		.wr_valid   (wr_valid),
		.wr_ready   (wr_ready),
		.wr_data    (wr_data)
	);

	// Hold unreduced work between front and back.
	rar_queue #(.DW(QW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_data  (wr_data),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_data  (rd_data)
	);

	// Back: reduce by the gcd and present the result beat.
	rar_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_valid   (rd_valid),
		.rd_ready   (rd_ready),
		.rd_data    (rd_data),
		.empty      (empty),
		.pop        (pop),
		.result_num (result_num),
		.result_den (result_den),
		.negative   (negative),
		.result_tag (result_tag)
	);

endmodule

// ===== sv/rar_front.sv =====
module rar_front #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  logic [1:0]                              action,
	input  logic [OPERAND_BITS-1:0]                 first_num,
	input  logic [OPERAND_BITS-1:0]                 first_den,
	input  logic [OPERAND_BITS-1:0]                 second_num,
	input  logic [OPERAND_BITS-1:0]                 second_den,
	input  logic [rar_pkg::TAG_BITS-1:0]            task_tag,
	output logic                                    wr_valid,
	input  logic                                    wr_ready,
	output logic [2*OPERAND_BITS+1+2*OPERAND_BITS+2+rar_pkg::TAG_BITS-1:0] wr_data
);

	localparam int PW = 2 * OPERAND_BITS;
	localparam int NB = PW + 1;

	logic                          valid_s1;
	rar_pkg::action_t              act_s1;
	logic [OPERAND_BITS-1:0]       a_s1, b_s1, c_s1, d_s1;
	logic [rar_pkg::TAG_BITS-1:0]  tag_s1;

	logic                          valid_s2;
	rar_pkg::action_t              act_s2;
	logic [PW-1:0]                 p_s2, q_s2, den_s2;
	logic [rar_pkg::TAG_BITS-1:0]  tag_s2;

	logic                          advance;
	logic                          take_s1;
	logic [OPERAND_BITS-1:0]       m0_rhs, m2_rhs;
	logic [PW-1:0]                 m0, m1, m2;
	logic [NB-1:0]                 num;
	logic                          neg;
	logic                          den_zero;

	assign advance = !valid_s2 || wr_ready;
	assign take_s1 = !valid_s1 || advance;
	assign full    = !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) valid_s1 <= push;
			if (advance) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && push) begin
			act_s1 <= rar_pkg::action_t'(action);
			a_s1   <= first_num;
			b_s1   <= first_den;
			c_s1   <= second_num;
			d_s1   <= second_den;
			tag_s1 <= task_tag;
		end
	end

	// Multiply uses a*c over b*d, divide a*d over b*c.
	assign m0_rhs = (act_s1 == rar_pkg::ACT_MUL) ? c_s1 : d_s1;
	assign m2_rhs = (act_s1 == rar_pkg::ACT_DIV) ? c_s1 : d_s1;
	assign m0 = PW'(a_s1) * PW'(m0_rhs);
	assign m1 = PW'(c_s1) * PW'(b_s1);
	assign m2 = PW'(b_s1) * PW'(m2_rhs);

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			act_s2 <= act_s1;
			p_s2   <= m0;
			q_s2   <= m1;
			den_s2 <= m2;
			tag_s2 <= tag_s1;
		end
	end

	always_comb begin
		neg = 1'b0;
		unique case (act_s2)
			rar_pkg::ACT_ADD: num = NB'(p_s2) + NB'(q_s2);
			rar_pkg::ACT_SUB: begin
				if (p_s2 >= q_s2) begin
					num = NB'(p_s2 - q_s2);
				end else begin
					num = NB'(q_s2 - p_s2);
					neg = 1'b1;
				end
			end
			default: num = NB'(p_s2);
		endcase
	end

	assign den_zero = (den_s2 == '0);
	assign wr_valid = valid_s2;
	assign wr_data  = {tag_s2, den_zero, neg, den_s2, num};

endmodule

// ===== sv/rar_queue.sv =====
module rar_queue #(
	parameter int DW = 73
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  logic [DW-1:0] wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [2];
	logic          wptr_q, rptr_q;
	logic [1:0]    cnt_q;
	logic          do_wr, do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_wr) wptr_q <= !wptr_q;
			if (do_rd) rptr_q <= !rptr_q;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_data;
	end

endmodule

// ===== sv/rar_back.sv =====
module rar_back #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_valid,
	output logic                           rd_ready,
	input  logic [2*OPERAND_BITS+1+2*OPERAND_BITS+2+rar_pkg::TAG_BITS-1:0] rd_data,
	output logic                           empty,
	input  logic                           pop,
	output logic [2*OPERAND_BITS:0]        result_num,
	output logic [2*OPERAND_BITS-1:0]      result_den,
	output logic                           negative,
	output logic [rar_pkg::TAG_BITS-1:0]   result_tag
);

	localparam int PW = 2 * OPERAND_BITS;
	localparam int NB = PW + 1;
	localparam int QW = NB + PW + 2 + rar_pkg::TAG_BITS;
	localparam int KB = $clog2(NB);
	localparam int CB = $clog2(NB + 1);

	rar_pkg::back_state_t          state_q;
	logic [NB-1:0]                 x_q, y_q, g_q;
	logic [KB-1:0]                 k_q;
	logic [NB-1:0]                 nq_q, dq_q, nr_q, dr_q;
	logic [CB-1:0]                 cnt_q;
	logic                          neg_q;
	logic [rar_pkg::TAG_BITS-1:0]  tag_q;

	logic                          out_valid_q;
	logic [NB-1:0]                 onum_q;
	logic [PW-1:0]                 oden_q;
	logic                          oneg_q;
	logic [rar_pkg::TAG_BITS-1:0]  otag_q;

	logic [NB-1:0]                 in_num;
	logic [PW-1:0]                 in_den;
	logic                          in_neg, in_dz;
	logic [rar_pkg::TAG_BITS-1:0]  in_tag;
	logic                          load, out_load, out_pop;
	logic [NB-1:0]                 g_shift;
	logic [NB:0]                   n_trial, d_trial;
	logic                          n_bit, d_bit;

	assign in_num = rd_data[NB-1:0];
	assign in_den = rd_data[NB+PW-1:NB];
	assign in_neg = rd_data[NB+PW];
	assign in_dz  = rd_data[NB+PW+1];
	assign in_tag = rd_data[QW-1 -: rar_pkg::TAG_BITS];

	assign rd_ready = (state_q == rar_pkg::ST_IDLE);
	assign load     = rd_ready && rd_valid;
	assign out_pop  = pop && out_valid_q;
	assign out_load = (state_q == rar_pkg::ST_DONE) && (!out_valid_q || out_pop);

	assign g_shift = x_q << k_q;

	assign n_trial = {nr_q, nq_q[NB-1]};
	assign d_trial = {dr_q, dq_q[NB-1]};
	assign n_bit   = (n_trial >= {1'b0, g_q});
	assign d_bit   = (d_trial >= {1'b0, g_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rar_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_pop) out_valid_q <= 1'b0;
			unique case (state_q)
				rar_pkg::ST_IDLE: begin
					if (load) begin
						if (in_dz || in_num == '0) state_q <= rar_pkg::ST_DONE;
						else state_q <= rar_pkg::ST_GCD;
					end
				end
				rar_pkg::ST_GCD: if (x_q == y_q) state_q <= rar_pkg::ST_DIV;
				rar_pkg::ST_DIV: if (cnt_q == CB'(NB - 1)) state_q <= rar_pkg::ST_DONE;
				rar_pkg::ST_DONE: if (out_load) state_q <= rar_pkg::ST_IDLE;
				default: state_q <= rar_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rar_pkg::ST_IDLE: begin
				if (load) begin
					tag_q <= in_tag;
					x_q   <= in_num;
					y_q   <= NB'(in_den);
					k_q   <= '0;
					if (in_dz) begin
						nq_q  <= '0;
						dq_q  <= '0;
						neg_q <= 1'b0;
					end else if (in_num == '0) begin
						nq_q  <= '0;
						dq_q  <= NB'(1);
						neg_q <= 1'b0;
					end else begin
						nq_q  <= in_num;
						dq_q  <= NB'(in_den);
						neg_q <= in_neg;
					end
				end
			end
			rar_pkg::ST_GCD: begin
				// Binary gcd: strip shared twos into k, then shrink the odd pair.
				if (x_q == y_q) begin
					g_q   <= g_shift;
					nr_q  <= '0;
					dr_q  <= '0;
					cnt_q <= '0;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + KB'(1);
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q > y_q) begin
					x_q <= (x_q - y_q) >> 1;
				end else begin
					y_q <= (y_q - x_q) >> 1;
				end
			end
			rar_pkg::ST_DIV: begin
				// Restoring division of both parts by the gcd, one bit a cycle.
				nr_q  <= n_bit ? NB'(n_trial - {1'b0, g_q}) : NB'(n_trial);
				dr_q  <= d_bit ? NB'(d_trial - {1'b0, g_q}) : NB'(d_trial);
				nq_q  <= {nq_q[NB-2:0], n_bit};
				dq_q  <= {dq_q[NB-2:0], d_bit};
				cnt_q <= cnt_q + CB'(1);
			end
			rar_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			onum_q <= nq_q;
			oden_q <= dq_q[PW-1:0];
			oneg_q <= neg_q;
			otag_q <= tag_q;
		end
	end

	assign empty      = !out_valid_q;
	assign result_num = onum_q;
	assign result_den = oden_q;
	assign negative   = oneg_q;
	assign result_tag = otag_q;

endmodule
